// ===== hdl/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// afs_pkg
// Shared constants, codes and types of the animation frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

   localparam int MAX_FRAMES   = 64;
   localparam int MAX_ADVANCES = 15;

   localparam int FRAME_IDX_W  = $clog2(MAX_FRAMES);
   localparam int FRAME_CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int ADV_CNT_W    = $clog2(MAX_ADVANCES + 1);

   localparam int SPRITE_W     = 16;
   localparam int DURATION_W   = 24;
   localparam int DELTA_W      = 16;
   localparam int SPEED_W      = 16;
   localparam int TIME_W       = 32;
   localparam int FRAC_W       = 8;
   localparam int ACTION_W     = 3;
   localparam int MODE_W       = 2;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 16;

   // Input actions.
   localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PLAY   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PAUSE  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RESUME = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd6;

   // Play modes.
   localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLAMP    = 2'd3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAY_MODE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED     = 8'd1;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

   // Operations of the shared time unit.
   localparam logic ALU_ADD_SAT = 1'b0;
   localparam logic ALU_SUB     = 1'b1;

   typedef struct packed {
      logic [FRAME_IDX_W-1:0] position;
      logic                   going_back;
      logic                   finished;
      logic                   playing;
      logic                   done;
   } adv_result_type;

endpackage

// ===== hdl/afs_frame_mem.sv =====
// ----------------------------------------------------------------------------
// afs_frame_mem
// Frame table: sprite index and duration per entry, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module afs_frame_mem (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [afs_pkg::FRAME_IDX_W-1:0]    wr_addr,
   input  logic [afs_pkg::SPRITE_W-1:0]       wr_sprite,
   input  logic [afs_pkg::DURATION_W-1:0]     wr_duration,
   input  logic [afs_pkg::FRAME_IDX_W-1:0]    rd_addr,
   output logic [afs_pkg::SPRITE_W-1:0]       rd_sprite,
   output logic [afs_pkg::DURATION_W-1:0]     rd_duration
);

   logic [afs_pkg::SPRITE_W-1:0]   sprite_mem   [afs_pkg::MAX_FRAMES];
   logic [afs_pkg::DURATION_W-1:0] duration_mem [afs_pkg::MAX_FRAMES];
   logic [afs_pkg::SPRITE_W-1:0]   rd_sprite_ff;
   logic [afs_pkg::DURATION_W-1:0] rd_duration_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sprite_mem[wr_addr]   <= wr_sprite;
         duration_mem[wr_addr] <= wr_duration;
      end
   end

   always_ff @(posedge clock) begin
      rd_sprite_ff   <= sprite_mem[rd_addr];
      rd_duration_ff <= duration_mem[rd_addr];
   end

   assign rd_sprite   = rd_sprite_ff;
   assign rd_duration = rd_duration_ff;

endmodule

// ===== hdl/afs_time_alu.sv =====
// ----------------------------------------------------------------------------
// afs_time_alu
// Shared 32-bit time unit: saturating add of the tick increment, or compare
// and subtract of a frame duration.
// ----------------------------------------------------------------------------
module afs_time_alu (
   input  logic                          op,
   input  logic [afs_pkg::TIME_W-1:0]    a,
   input  logic [afs_pkg::TIME_W-1:0]    b,
   output logic [afs_pkg::TIME_W-1:0]    result,
   output logic                          ge
);

   logic [afs_pkg::TIME_W-1:0] b_eff;
   logic [afs_pkg::TIME_W:0]   sum;

   always_comb begin
      b_eff = (op == afs_pkg::ALU_SUB) ? ~b : b;
      sum   = {1'b0, a} + {1'b0, b_eff} + {{afs_pkg::TIME_W{1'b0}}, op};
      // For a subtract the carry out means no borrow, so a >= b.
      ge    = sum[afs_pkg::TIME_W];
      if (op == afs_pkg::ALU_ADD_SAT && sum[afs_pkg::TIME_W]) begin
         result = {afs_pkg::TIME_W{1'b1}};
      end else begin
         result = sum[afs_pkg::TIME_W-1:0];
      end
   end

endmodule

// ===== hdl/afs_advance.sv =====
// ----------------------------------------------------------------------------
// afs_advance
// Next frame position and playback flags for one advance in the selected
// play mode.
// ----------------------------------------------------------------------------
module afs_advance (
   input  logic [afs_pkg::MODE_W-1:0]       play_mode,
   input  logic [afs_pkg::FRAME_CNT_W-1:0]  frame_total,
   input  logic [afs_pkg::FRAME_IDX_W-1:0]  position,
   input  logic                             going_back,
   input  logic                             finished,
   input  logic                             playing,
   output afs_pkg::adv_result_type          adv
);

   logic [afs_pkg::FRAME_CNT_W-1:0] pos_plus1;
   logic                            at_end;
   logic [afs_pkg::FRAME_CNT_W-1:0] turn_pos;

   always_comb begin
      pos_plus1 = afs_pkg::FRAME_CNT_W'(position) + 1'b1;
      at_end    = (pos_plus1 >= frame_total);
      turn_pos  = frame_total - afs_pkg::FRAME_CNT_W'(2);

      adv.position   = position;
      adv.going_back = going_back;
      adv.finished   = finished;
      adv.playing    = playing;
      adv.done       = 1'b0;

      unique case (play_mode)
         afs_pkg::MODE_ONCE: begin
            if (at_end) begin
               adv.finished = 1'b1;
               adv.playing  = 1'b0;
               adv.done     = 1'b1;
            end else begin
               adv.position = pos_plus1[afs_pkg::FRAME_IDX_W-1:0];
            end
         end
         afs_pkg::MODE_LOOP: begin
            adv.position = at_end ? '0 : pos_plus1[afs_pkg::FRAME_IDX_W-1:0];
         end
         afs_pkg::MODE_PINGPONG: begin
            if (frame_total <= afs_pkg::FRAME_CNT_W'(1)) begin
               adv.position   = '0;
               adv.going_back = 1'b0;
            end else if (going_back) begin
               if (position == '0) begin
                  adv.going_back = 1'b0;
                  adv.position   = afs_pkg::FRAME_IDX_W'(1);
               end else begin
                  adv.position = position - 1'b1;
               end
            end else if (at_end) begin
               adv.going_back = 1'b1;
               adv.position   = turn_pos[afs_pkg::FRAME_IDX_W-1:0];
            end else begin
               adv.position = pos_plus1[afs_pkg::FRAME_IDX_W-1:0];
            end
         end
         default: begin
            if (at_end) begin
               adv.finished = 1'b1;
            end else begin
               adv.position = pos_plus1[afs_pkg::FRAME_IDX_W-1:0];
            end
         end
      endcase
   end

endmodule

// ===== hdl/animation_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// animation_frame_sequencer
// Sprite animation sequencer: frame table, running frame time and play modes.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Each word
// produces one or more result words on the rsp_ ports, each valid for exactly
// one cycle with rsp_valid high; the final word of a command has rsp_last set.
// The receiver cannot stall, so results are never held back.
// Registers (play_mode, speed) are written through the csr_ channel, which is
// always ready; write them only while the block is idle.
// A non-tick command, and a tick while not playing or on an empty table,
// keeps busy high through the execute and wait states and the final word.
// Any other tick adds the tick increment, then makes up to 15 frame
// advances, each a compare/subtract on the shared time unit, a frame table
// read and a result word; it ends on a finish, on the advance limit, or
// when the frame time falls short of the current frame duration.
// Reset (synchronous, active high) clears the frame count, position, frame
// time and flags and loads the register defaults; the frame table itself is
// not cleared, since only entries below the frame count are ever used.
// ----------------------------------------------------------------------------
module animation_frame_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [afs_pkg::ACTION_W-1:0]       req_action,
   input  logic [afs_pkg::DELTA_W-1:0]        req_delta_time,
   input  logic [afs_pkg::SPRITE_W-1:0]       req_frame_sprite,
   input  logic [afs_pkg::DURATION_W-1:0]     req_frame_duration,
   output logic                               rsp_valid,
   output logic [afs_pkg::SPRITE_W-1:0]       rsp_sprite_index,
   output logic                               rsp_frame_changed,
   output logic                               rsp_completed,
   output logic                               rsp_playing,
   output logic                               rsp_finished,
   output logic                               rsp_still_running,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [afs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [afs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_ADD      = 3'd2;
   localparam logic [2:0] S_CMP      = 3'd3;
   localparam logic [2:0] S_WAIT_ADV = 3'd4;
   localparam logic [2:0] S_ADV_OUT  = 3'd5;
   localparam logic [2:0] S_WAIT     = 3'd6;
   localparam logic [2:0] S_FINAL    = 3'd7;

   logic [2:0]                         state_ff, state_in;
   logic [afs_pkg::MODE_W-1:0]         play_mode_ff, play_mode_in;
   logic [afs_pkg::SPEED_W-1:0]        speed_ff, speed_in;
   logic [afs_pkg::FRAME_CNT_W-1:0]    frame_total_ff, frame_total_in;
   logic [afs_pkg::FRAME_IDX_W-1:0]    position_ff, position_in;
   logic [afs_pkg::TIME_W-1:0]         elapsed_ff, elapsed_in;
   logic                               playing_ff, playing_in;
   logic                               finished_ff, finished_in;
   logic                               going_back_ff, going_back_in;
   logic [afs_pkg::ADV_CNT_W-1:0]      adv_cnt_ff, adv_cnt_in;
   logic                               running_ff, running_in;
   logic                               changed_ff, changed_in;
   logic                               done_ff, done_in;

   logic [afs_pkg::ACTION_W-1:0]       action_ff;
   logic [afs_pkg::DELTA_W-1:0]        delta_ff;
   logic [afs_pkg::SPRITE_W-1:0]       sprite_ff;
   logic [afs_pkg::DURATION_W-1:0]     duration_ff;
   logic [afs_pkg::TIME_W-1:0]         prod_ff;

   logic                               accept;
   logic                               mem_wr_en;
   logic [afs_pkg::SPRITE_W-1:0]       rd_sprite;
   logic [afs_pkg::DURATION_W-1:0]     rd_duration;
   logic                               alu_op;
   logic [afs_pkg::TIME_W-1:0]         alu_b;
   logic [afs_pkg::TIME_W-1:0]         alu_result;
   logic                               alu_ge;
   logic [afs_pkg::TIME_W-1:0]         frame_len;
   afs_pkg::adv_result_type            adv;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   afs_frame_mem u_mem (
      .clock       (clock),
      .wr_en       (mem_wr_en),
      .wr_addr     (frame_total_ff[afs_pkg::FRAME_IDX_W-1:0]),
      .wr_sprite   (sprite_ff),
      .wr_duration (duration_ff),
      .rd_addr     (position_ff),
      .rd_sprite   (rd_sprite),
      .rd_duration (rd_duration)
   );

   // A zero duration counts as one time unit; durations compare in Q24.8.
   assign frame_len = (rd_duration == '0) ? afs_pkg::TIME_W'(1 << afs_pkg::FRAC_W)
                                          : {rd_duration, {afs_pkg::FRAC_W{1'b0}}};

   assign alu_op = (state_ff == S_ADD) ? afs_pkg::ALU_ADD_SAT : afs_pkg::ALU_SUB;
   assign alu_b  = (state_ff == S_ADD) ? prod_ff : frame_len;

   afs_time_alu u_alu (
      .op     (alu_op),
      .a      (elapsed_ff),
      .b      (alu_b),
      .result (alu_result),
      .ge     (alu_ge)
   );

   afs_advance u_adv (
      .play_mode   (play_mode_ff),
      .frame_total (frame_total_ff),
      .position    (position_ff),
      .going_back  (going_back_ff),
      .finished    (finished_ff),
      .playing     (playing_ff),
      .adv         (adv)
   );

   always_comb begin
      state_in       = state_ff;
      play_mode_in   = play_mode_ff;
      speed_in       = speed_ff;
      frame_total_in = frame_total_ff;
      position_in    = position_ff;
      elapsed_in     = elapsed_ff;
      playing_in     = playing_ff;
      finished_in    = finished_ff;
      going_back_in  = going_back_ff;
      adv_cnt_in     = adv_cnt_ff;
      running_in     = running_ff;
      changed_in     = changed_ff;
      done_in        = done_ff;
      mem_wr_en      = 1'b0;

      if (csr_valid && csr_ready) begin
         if (csr_index == afs_pkg::CSR_PLAY_MODE) begin
            play_mode_in = csr_wdata[afs_pkg::MODE_W-1:0];
         end else if (csr_index == afs_pkg::CSR_SPEED) begin
            speed_in = csr_wdata[afs_pkg::SPEED_W-1:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            running_in = 1'b0;
            state_in   = S_WAIT;
            unique case (action_ff)
               afs_pkg::ACT_TICK: begin
                  if (playing_ff && frame_total_ff != '0) begin
                     state_in = S_ADD;
                  end
               end
               afs_pkg::ACT_PLAY: begin
                  playing_in    = 1'b1;
                  finished_in   = 1'b0;
                  elapsed_in    = '0;
                  position_in   = '0;
                  going_back_in = 1'b0;
               end
               afs_pkg::ACT_PAUSE: begin
                  playing_in = 1'b0;
               end
               afs_pkg::ACT_RESUME: begin
                  if (!finished_ff) begin
                     playing_in = 1'b1;
                  end
               end
               afs_pkg::ACT_STOP: begin
                  playing_in    = 1'b0;
                  finished_in   = 1'b0;
                  elapsed_in    = '0;
                  position_in   = '0;
                  going_back_in = 1'b0;
               end
               afs_pkg::ACT_APPEND: begin
                  if (frame_total_ff < afs_pkg::FRAME_CNT_W'(afs_pkg::MAX_FRAMES)) begin
                     mem_wr_en      = 1'b1;
                     frame_total_in = frame_total_ff + 1'b1;
                  end
               end
               afs_pkg::ACT_CLEAR: begin
                  frame_total_in = '0;
                  position_in    = '0;
                  elapsed_in     = '0;
                  going_back_in  = 1'b0;
               end
               default: begin
               end
            endcase
         end
         S_ADD: begin
            elapsed_in = alu_result;
            adv_cnt_in = '0;
            state_in   = S_CMP;
         end
         S_CMP: begin
            if (alu_ge) begin
               elapsed_in    = alu_result;
               position_in   = adv.position;
               going_back_in = adv.going_back;
               finished_in   = adv.finished;
               playing_in    = adv.playing;
               changed_in    = (adv.position != position_ff);
               done_in       = adv.done;
               adv_cnt_in    = adv_cnt_ff + 1'b1;
               state_in      = S_WAIT_ADV;
            end else begin
               running_in = 1'b1;
               state_in   = S_FINAL;
            end
         end
         S_WAIT_ADV: begin
            state_in = S_ADV_OUT;
         end
         S_ADV_OUT: begin
            priority if (finished_ff) begin
               running_in = 1'b0;
               state_in   = S_FINAL;
            end else if (adv_cnt_ff == afs_pkg::ADV_CNT_W'(afs_pkg::MAX_ADVANCES)) begin
               running_in = 1'b1;
               state_in   = S_FINAL;
            end else begin
               state_in = S_CMP;
            end
         end
         S_WAIT: begin
            state_in = S_FINAL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         play_mode_ff   <= afs_pkg::MODE_ONCE;
         speed_ff       <= afs_pkg::SPEED_RESET;
         frame_total_ff <= '0;
         position_ff    <= '0;
         elapsed_ff     <= '0;
         playing_ff     <= 1'b0;
         finished_ff    <= 1'b0;
         going_back_ff  <= 1'b0;
         adv_cnt_ff     <= '0;
         running_ff     <= 1'b0;
         changed_ff     <= 1'b0;
         done_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         play_mode_ff   <= play_mode_in;
         speed_ff       <= speed_in;
         frame_total_ff <= frame_total_in;
         position_ff    <= position_in;
         elapsed_ff     <= elapsed_in;
         playing_ff     <= playing_in;
         finished_ff    <= finished_in;
         going_back_ff  <= going_back_in;
         adv_cnt_ff     <= adv_cnt_in;
         running_ff     <= running_in;
         changed_ff     <= changed_in;
         done_ff        <= done_in;
      end
   end

   // Command word capture and the tick increment, delta times speed in Q24.8.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff   <= req_action;
         delta_ff    <= req_delta_time;
         sprite_ff   <= req_frame_sprite;
         duration_ff <= req_frame_duration;
      end
      if (state_ff == S_EXEC) begin
         prod_ff <= afs_pkg::TIME_W'(delta_ff) * afs_pkg::TIME_W'(speed_ff);
      end
   end

   always_comb begin
      rsp_valid         = (state_ff == S_ADV_OUT) || (state_ff == S_FINAL);
      rsp_sprite_index  = (frame_total_ff == '0) ? '0 : rd_sprite;
      rsp_frame_changed = (state_ff == S_ADV_OUT) && changed_ff;
      rsp_completed     = (state_ff == S_ADV_OUT) && done_ff;
      rsp_playing       = playing_ff;
      rsp_finished      = finished_ff;
      rsp_still_running = (state_ff == S_FINAL) && running_ff;
      rsp_last          = (state_ff == S_FINAL);
   end

   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word while the sequencer is idle");

   a_pos_in_table: assert property (@(posedge clock) disable iff (reset)
      (frame_total_ff != '0) |-> (afs_pkg::FRAME_CNT_W'(position_ff) < frame_total_ff))
      else $error("frame position beyond the frame count");

   a_last_ends_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("sequencer still busy after the final result word");

   a_adv_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (adv_cnt_ff < afs_pkg::ADV_CNT_W'(afs_pkg::MAX_ADVANCES)))
      else $error("advance count past the per-tick limit");

endmodule
